### src/pbbp_pkg.sv
package pbbp_pkg;

  localparam int BLOCKS_PER_STORAGE = 4096;
  localparam int BC_W      = $clog2(BLOCKS_PER_STORAGE + 1);
  localparam int PAL_W     = 13;
  localparam int WORD_W    = 32;
  localparam int BUF_DEPTH = 7;
  localparam int CNT_W     = 3;
  localparam int VARINT_MAX = 5;

  typedef struct packed {
    logic [BUF_DEPTH-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      done;
  } pbbp_run_t;

  typedef struct packed {
    logic [VARINT_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]           cnt;
  } pbbp_varint_t;

  // bits per block from the palette length
  function automatic logic [4:0] field_width(input logic [PAL_W-1:0] len);
    logic [4:0] w;
    if (len <= PAL_W'(2))        w = 5'd1;
    else if (len <= PAL_W'(4))   w = 5'd2;
    else if (len <= PAL_W'(8))   w = 5'd3;
    else if (len <= PAL_W'(16))  w = 5'd4;
    else if (len <= PAL_W'(32))  w = 5'd5;
    else if (len <= PAL_W'(64))  w = 5'd6;
    else if (len <= PAL_W'(256)) w = 5'd8;
    else                         w = 5'd16;
    return w;
  endfunction

  function automatic logic [5:0] per_word(input logic [4:0] w);
    logic [5:0] n;
    case (w)
      5'd1:    n = 6'd32;
      5'd2:    n = 6'd16;
      5'd3:    n = 6'd10;
      5'd4:    n = 6'd8;
      5'd5:    n = 6'd6;
      5'd6:    n = 6'd5;
      5'd8:    n = 6'd4;
      default: n = 6'd2;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] zigzag(input logic [31:0] v);
    return {v[30:0], 1'b0} ^ {32{v[31]}};
  endfunction

  function automatic pbbp_varint_t varint(input logic [31:0] zig);
    pbbp_varint_t r;
    logic [CNT_W-1:0] n;
    logic [31:0] sh;
    n = CNT_W'(1);
    if (zig[31:7] != '0)  n = CNT_W'(2);
    if (zig[31:14] != '0) n = CNT_W'(3);
    if (zig[31:21] != '0) n = CNT_W'(4);
    if (zig[31:28] != '0) n = CNT_W'(5);
    for (int k = 0; k < VARINT_MAX; k++) begin
      sh = zig >> (7 * k);
      r.bytes[k] = {(CNT_W'(k + 1) < n), sh[6:0]};
    end
    r.cnt = n;
    return r;
  endfunction

endpackage

### src/pbbp_pack.sv
module pbbp_pack (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pbbp_pkg::PAL_W-1:0] cfg_data,
  input  logic                       item_we,
  input  logic signed [31:0]         item_value,
  output pbbp_pkg::pbbp_run_t        run
);
  import pbbp_pkg::*;

  logic [PAL_W-1:0]  pal_len_r;
  logic [BC_W-1:0]   block_count_r, block_count_nxt;
  logic [4:0]        slot_r, slot_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [PAL_W-1:0]  pal_count_r, pal_count_nxt;

  logic [4:0]        width;
  logic [31:0]       mask;
  logic [9:0]        shift;
  logic [WORD_W-1:0] acc_new;
  logic              complete;
  logic              last_block;
  logic              block_phase;
  pbbp_varint_t      len_vi;
  pbbp_varint_t      val_vi;
  logic [CNT_W-1:0]  p;

  assign width       = field_width(pal_len_r);
  assign mask        = (32'd1 << width) - 32'd1;
  assign shift       = 10'(slot_r) * 10'(width);
  assign acc_new     = (shift < 10'd32) ? (acc_r | ((item_value & mask) << shift[4:0])) : acc_r;
  assign block_phase = block_count_r < BC_W'(BLOCKS_PER_STORAGE);
  assign last_block  = block_count_r == BC_W'(BLOCKS_PER_STORAGE - 1);
  assign complete    = (6'(slot_r) + 6'd1 >= per_word(width)) || last_block;
  assign len_vi      = varint(zigzag(32'(pal_len_r)));
  assign val_vi      = varint(zigzag(item_value));

  always_comb begin
    run             = '0;
    p               = '0;
    block_count_nxt = block_count_r;
    slot_nxt        = slot_r;
    acc_nxt         = acc_r;
    pal_count_nxt   = pal_count_r;
    if (block_phase) begin
      if (block_count_r == '0) begin
        run.bytes[p] = {2'b00, width, 1'b1};
        p = p + CNT_W'(1);
      end
      block_count_nxt = block_count_r + BC_W'(1);
      if (complete) begin
        for (int k = 0; k < 4; k++) begin
          run.bytes[p + CNT_W'(k)] = acc_new[8*k +: 8];
        end
        p        = p + CNT_W'(4);
        acc_nxt  = '0;
        slot_nxt = '0;
      end else begin
        acc_nxt  = acc_new;
        slot_nxt = slot_r + 5'd1;
      end
      if (last_block) begin
        // palette length fits in two varint bytes
        for (int k = 0; k < 2; k++) begin
          if (CNT_W'(k) < len_vi.cnt) run.bytes[p + CNT_W'(k)] = len_vi.bytes[k];
        end
        p = p + len_vi.cnt;
        if (pal_len_r == '0) run.done = 1'b1;
      end
    end else begin
      for (int k = 0; k < VARINT_MAX; k++) begin
        run.bytes[k] = val_vi.bytes[k];
      end
      p = val_vi.cnt;
      if ({1'b0, pal_count_r} + (PAL_W + 1)'(1) >= {1'b0, pal_len_r}) run.done = 1'b1;
      else pal_count_nxt = pal_count_r + PAL_W'(1);
    end
    run.cnt = p;
    if (run.done) begin
      block_count_nxt = '0;
      slot_nxt        = '0;
      acc_nxt         = '0;
      pal_count_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_len_r     <= PAL_W'(1);
      block_count_r <= '0;
      slot_r        <= '0;
      acc_r         <= '0;
      pal_count_r   <= '0;
    end else begin
      if (cfg_we) pal_len_r <= cfg_data;
      if (item_we) begin
        block_count_r <= block_count_nxt;
        slot_r        <= slot_nxt;
        acc_r         <= acc_nxt;
        pal_count_r   <= pal_count_nxt;
      end
    end
  end

endmodule

### src/palette_block_bit_packer_unit.sv
// palette block storage packer
// in channel (in_valid/in_ready/in_value): 4096 block indices, then one
// palette entry per item until the configured number of entries has gone by;
// the next item then starts a new storage.
// cfg channel (cfg_valid/cfg_ready/cfg_pal_len): always ready,
// write it only while no bytes are pending.
// out channel: one byte per transfer, out_run_end marks the last byte caused by
// an input item, out_stream_end the last byte of the storage.
// each accepted item is turned into its bytes in the cycle it is taken and
// parked in a 7-byte run buffer, from which its first byte moves on to the
// out register. bytes leave at one per cycle while the receiver is ready;
// most block items make no byte, the first block the header byte, a
// word-completing block 4 to 6, a palette entry 1 to 5. the next item is
// taken in the cycle the last byte of the current run moves to the out
// register. a stalled receiver holds the out register and the run buffer;
// in_ready drops until the buffer drains.
// reset (synchronous, rst_n low) clears all counters and the buffer and sets
// the palette length to 1.
module palette_block_bit_packer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pbbp_pkg::PAL_W-1:0] cfg_pal_len,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_run_end,
  output logic                       out_stream_end
);
  import pbbp_pkg::*;

  pbbp_run_t                 run;
  logic [BUF_DEPTH-1:0][7:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]          buf_cnt_r, buf_cnt_nxt;
  logic                      buf_done_r, buf_done_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_byte_r, out_byte_nxt;
  logic                      out_run_end_r, out_run_end_nxt;
  logic                      out_stream_end_r, out_stream_end_nxt;
  logic                      move;
  logic                      accept;

  assign cfg_ready = 1'b1;
  assign move      = (buf_cnt_r != '0) && (!out_valid_r || out_ready);
  assign in_ready  = (buf_cnt_r == '0) || ((buf_cnt_r == CNT_W'(1)) && move);
  assign accept    = in_valid && in_ready;

  pbbp_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_pal_len),
    .item_we    (accept),
    .item_value (in_value),
    .run        (run)
  );

  always_comb begin
    buf_nxt            = buf_r;
    buf_cnt_nxt        = buf_cnt_r;
    buf_done_nxt       = buf_done_r;
    out_valid_nxt      = out_valid_r;
    out_byte_nxt       = out_byte_r;
    out_run_end_nxt    = out_run_end_r;
    out_stream_end_nxt = out_stream_end_r;
    if (move) begin
      out_valid_nxt      = 1'b1;
      out_byte_nxt       = buf_r[0];
      out_run_end_nxt    = buf_cnt_r == CNT_W'(1);
      out_stream_end_nxt = (buf_cnt_r == CNT_W'(1)) && buf_done_r;
      for (int k = 0; k < BUF_DEPTH - 1; k++) begin
        buf_nxt[k] = buf_r[k + 1];
      end
      buf_cnt_nxt = buf_cnt_r - CNT_W'(1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      buf_nxt      = run.bytes;
      buf_cnt_nxt  = run.cnt;
      buf_done_nxt = run.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r   <= '0;
      buf_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      buf_cnt_r   <= buf_cnt_nxt;
      buf_done_r  <= buf_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r            <= buf_nxt;
    out_byte_r       <= out_byte_nxt;
    out_run_end_r    <= out_run_end_nxt;
    out_stream_end_r <= out_stream_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_end    = out_run_end_r;
  assign out_stream_end = out_stream_end_r;

endmodule

### src/pbbp_checker.sv
module pbbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_end,
  input logic       out_stream_end
);

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_run_end)
      && $stable(out_stream_end))
    else $error("stalled byte changed");

  // the storage ends only on the last byte of an item
  a_stream_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_end |-> out_run_end)
    else $error("stream end without run end");

  // bytes of one run follow without gaps
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_end |=> out_valid)
    else $error("gap inside a run");

  // no new item while a run is stalled at the output before its last byte
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !out_run_end |-> !(in_valid && in_ready))
    else $error("item taken during a stalled run");

endmodule

bind palette_block_bit_packer_unit pbbp_checker u_pbbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_run_end    (out_run_end),
  .out_stream_end (out_stream_end)
);

### tb/palette_block_bit_packer_unit_test.sv
`timescale 1ns / 1ps

module palette_block_bit_packer_unit_test;
  import pbbp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int PLAN_ROWS = 25;
  localparam int N_STORAGES = 8;

  typedef enum logic [1:0] {ROW_ITEM, ROW_FILL, ROW_CFG} row_kind_t;

  // typed rows carry up to five bytes, byte 0 in the low bits
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] arg;
    logic        typed;
    logic [2:0]  n;
    logic [39:0] bytes;
    logic        ends;
  } step_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
  } byte_rec_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [PAL_W-1:0]     cfg_pal_len = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [31:0]   in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_run_end;
  logic                 out_stream_end;

  // packer state as the predictor sees it
  logic [PAL_W-1:0] pal_len = 13'd1;
  logic [12:0]      blk_cnt = '0;
  logic [4:0]       slot = '0;
  logic [31:0]      acc = '0;
  logic [12:0]      pal_cnt = '0;

  logic [7:0] item_bytes[$];
  bit         item_ends_storage;
  byte_rec_t  due_bytes[$];

  step_row_t plan [0:PLAN_ROWS-1];
  step_row_t cur_row;
  bit        use_typed = 0;
  bit        idle_on = 1;
  bit        quiet = 0;
  int        items_sent = 0;
  int        storages_done = 0;
  int        cfg_writes = 0;
  int        bytes_seen = 0;
  int        errors = 0;

  palette_block_bit_packer_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_pal_len(cfg_pal_len),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_run_end(out_run_end),
    .out_stream_end(out_stream_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int field_bits(input logic [PAL_W-1:0] len);
    int w = 2;
    if (len <= 2) return 1;
    while (w < 16 && (1 << w) < len) w++;
    if (w == 7) w = 8;
    if (w > 8) w = 16;
    return w;
  endfunction

  function automatic logic [31:0] zz_encode(input logic [31:0] v);
    return (v << 1) ^ (v[31] ? 32'hFFFF_FFFF : 32'h0000_0000);
  endfunction

  function automatic logic [31:0] palette_value();
    case ($urandom_range(0, 2))
      0: return 32'($urandom_range(0, 127)) - 32'd64;
      1: return $urandom;
      default: return $urandom >> $urandom_range(1, 31);
    endcase
  endfunction

  // bytes caused by one item, left in item_bytes
  task automatic serialize_item(input logic [31:0] v);
    int w;
    int per_word;
    int shift;
    logic [31:0] mask;
    logic [31:0] zz;
    logic [6:0] low7;
    bit last_blk;
    bit has_varint;
    w = field_bits(pal_len);
    item_bytes.delete();
    item_ends_storage = 0;
    has_varint = 0;
    zz = '0;
    if (blk_cnt < BLOCKS_PER_STORAGE) begin
      per_word = 32 / w;
      mask = (32'd1 << w) - 32'd1;
      shift = slot * w;
      last_blk = (blk_cnt + 1 >= BLOCKS_PER_STORAGE);
      if (blk_cnt == 0) item_bytes.push_back(8'((w << 1) | 1));
      // slots pushed past the word by a width change add nothing
      if (shift < 32) acc = acc | ((v & mask) << shift);
      blk_cnt = blk_cnt + 1'b1;
      if (slot + 1 >= per_word || last_blk) begin
        for (int k = 0; k < 4; k++) item_bytes.push_back(acc[8*k +: 8]);
        acc = '0;
        slot = '0;
      end else begin
        slot = slot + 1'b1;
      end
      if (last_blk) begin
        has_varint = 1;
        zz = zz_encode({19'd0, pal_len});
        item_ends_storage = (pal_len == 0);
      end
    end else begin
      has_varint = 1;
      zz = zz_encode(v);
      if (pal_cnt + 1 >= pal_len) item_ends_storage = 1;
      else pal_cnt = pal_cnt + 1'b1;
    end
    if (has_varint) begin
      do begin
        low7 = zz[6:0];
        zz = zz >> 7;
        item_bytes.push_back({zz != 0, low7});
      end while (zz != 0);
    end
    if (item_ends_storage) begin
      blk_cnt = '0;
      slot = '0;
      acc = '0;
      pal_cnt = '0;
    end
  endtask

  task automatic push_value(input logic [31:0] v);
    byte_rec_t rec;
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    serialize_item(v);
    if (use_typed) begin
      item_bytes.delete();
      for (int k = 0; k < cur_row.n; k++) item_bytes.push_back(cur_row.bytes[8*k +: 8]);
      item_ends_storage = cur_row.ends;
    end
    foreach (item_bytes[k]) begin
      rec.data = item_bytes[k];
      rec.run_end = (k == item_bytes.size() - 1);
      rec.stream_end = rec.run_end && item_ends_storage;
      due_bytes.push_back(rec);
    end
    if (item_ends_storage) storages_done++;
    items_sent++;
    if (items_sent % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
    if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_bytes();
    while (due_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic set_pal_len(input logic [PAL_W-1:0] len);
    in_valid <= 1'b0;
    drain_bytes();
    // a block item with no bytes may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_pal_len <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pal_len = len;
    cfg_writes++;
  endtask

  // receiver: short random stalls, plus one long hold-off early on
  initial begin : sink
    int taken = 0;
    bit held = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (!held && taken >= 60) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_out
    byte_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      bytes_seen++;
      if (due_bytes.size() == 0) begin
        $display("%0t: byte %02h arrived with nothing due", $time, out_byte);
        errors++;
      end else begin
        want = due_bytes.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
          errors++;
        end
        if (out_run_end !== want.run_end) begin
          $display("%0t: out_run_end expected %0b actual %0b",
                   $time, want.run_end, out_run_end);
          errors++;
        end
        if (out_stream_end !== want.stream_end) begin
          $display("%0t: out_stream_end expected %0b actual %0b",
                   $time, want.stream_end, out_stream_end);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: no handshake for %0d cycles, %0d bytes still due",
             $time, STALL_LIMIT, due_bytes.size());
    $display("palette_block_bit_packer_unit: mismatch");
    $finish;
  end

  initial begin
    int retune_at;
    int cut_at;
    logic [PAL_W-1:0] new_len;
    bit over;

    // reset length is 1: one bit per block, header 03
    plan[0]  = '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 3'd1, 40'h03, 1'b0};
    plan[1]  = '{ROW_ITEM, 32'h8000_0000, 1'b1, 3'd0, 40'h00, 1'b0};
    plan[2]  = '{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, 3'd0, 40'h00, 1'b0};
    plan[3]  = '{ROW_ITEM, 32'h0000_0001, 1'b0, 3'd0, 40'h00, 1'b0};
    plan[4]  = '{ROW_FILL, 32'd4095,      1'b0, 3'd0, 40'h00, 1'b0};
    // final block flushes the part word and sends the length
    plan[5]  = '{ROW_ITEM, 32'h0000_0055, 1'b0, 3'd0, 40'h00, 1'b0};
    plan[6]  = '{ROW_ITEM, 32'h8000_0000, 1'b1, 3'd5, 40'h0F_FFFF_FFFF, 1'b1};
    // zero length: stream ends on the length byte
    plan[7]  = '{ROW_CFG,  32'd0,         1'b0, 3'd0, 40'h00, 1'b0};
    plan[8]  = '{ROW_ITEM, 32'h0000_0000, 1'b1, 3'd1, 40'h03, 1'b0};
    plan[9]  = '{ROW_FILL, 32'd4095,      1'b0, 3'd0, 40'h00, 1'b0};
    plan[10] = '{ROW_ITEM, 32'h0000_0001, 1'b0, 3'd0, 40'h00, 1'b0};
    // widest field
    plan[11] = '{ROW_CFG,  32'd8191,      1'b0, 3'd0, 40'h00, 1'b0};
    plan[12] = '{ROW_ITEM, 32'h1234_5678, 1'b1, 3'd1, 40'h21, 1'b0};
    plan[13] = '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 3'd4, 40'h00_FFFF_5678, 1'b0};
    // width jumps from 1 to 16 with slot 20 pending
    plan[14] = '{ROW_CFG,  32'd2,         1'b0, 3'd0, 40'h00, 1'b0};
    plan[15] = '{ROW_FILL, 32'd22,        1'b0, 3'd0, 40'h00, 1'b0};
    plan[16] = '{ROW_CFG,  32'd4096,      1'b0, 3'd0, 40'h00, 1'b0};
    plan[17] = '{ROW_ITEM, 32'h0000_ABCD, 1'b0, 3'd0, 40'h00, 1'b0};
    plan[18] = '{ROW_FILL, 32'd4095,      1'b0, 3'd0, 40'h00, 1'b0};
    plan[19] = '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 3'd0, 40'h00, 1'b0};
    // palette phase, then length cut below the count
    plan[20] = '{ROW_CFG,  32'd3,         1'b0, 3'd0, 40'h00, 1'b0};
    plan[21] = '{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, 3'd5, 40'h0F_FFFF_FFFE, 1'b0};
    plan[22] = '{ROW_ITEM, 32'h0000_0000, 1'b0, 3'd0, 40'h00, 1'b0};
    plan[23] = '{ROW_CFG,  32'd1,         1'b0, 3'd0, 40'h00, 1'b0};
    plan[24] = '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 3'd1, 40'h01, 1'b1};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      cur_row = plan[r];
      case (cur_row.kind)
        ROW_CFG: set_pal_len(cur_row.arg[PAL_W-1:0]);
        ROW_FILL: begin
          while (blk_cnt < cur_row.arg) push_value($urandom);
        end
        default: begin
          use_typed = cur_row.typed;
          push_value(cur_row.arg);
          use_typed = 0;
        end
      endcase
    end

    // one storage per field width from 2 to 16, then a last one with no idling
    for (int s = 0; s < N_STORAGES; s++) begin
      quiet = (s == N_STORAGES - 1);
      case (s)
        0: new_len = PAL_W'($urandom_range(3, 4));
        1: new_len = PAL_W'($urandom_range(5, 8));
        2: new_len = PAL_W'($urandom_range(9, 16));
        3: new_len = PAL_W'($urandom_range(17, 32));
        4: new_len = PAL_W'($urandom_range(33, 64));
        5: new_len = PAL_W'($urandom_range(65, 256));
        6: new_len = PAL_W'($urandom_range(257, 8191));
        default: new_len = PAL_W'($urandom_range(0, 40));
      endcase
      set_pal_len(new_len);
      retune_at = ($urandom_range(0, 1) != 0) ? $urandom_range(1, BLOCKS_PER_STORAGE - 2) : -1;
      cut_at = $urandom_range(4, 30);
      over = 0;
      while (!over) begin
        if (blk_cnt == retune_at) begin
          set_pal_len(PAL_W'($urandom_range(0, 8191)));
          retune_at = -1;
        end
        // keep long palettes short by lowering the length part way
        if (blk_cnt == BLOCKS_PER_STORAGE && pal_cnt == cut_at && pal_len > cut_at + 1) begin
          set_pal_len(PAL_W'($urandom_range(0, cut_at + 2)));
          cut_at = -1;
        end
        if (blk_cnt < BLOCKS_PER_STORAGE) push_value($urandom);
        else push_value(palette_value());
        over = item_ends_storage;
      end
    end

    in_valid <= 1'b0;
    drain_bytes();
    repeat (10) @(posedge clk);

    $display("covered %0d storages over %0d items with %0d palette length writes",
             storages_done, items_sent, cfg_writes);
    $display("%0d bytes compared, %0d field errors", bytes_seen, errors);
    if (errors == 0) begin
      $display("palette_block_bit_packer_unit: match");
    end else begin
      $display("palette_block_bit_packer_unit: mismatch");
    end
    $finish;
  end

endmodule
